@@ rtl/spq_pkg.sv @@
package spq_pkg;

    localparam int KEY_W    = 32;
    localparam int ITEM_W   = 16;
    localparam int REQ_W    = 2;
    localparam int STATUS_W = 2;

    typedef logic [KEY_W-1:0]    key_t;
    typedef logic [ITEM_W-1:0]   item_t;
    typedef logic [REQ_W-1:0]    req_code_t;
    typedef logic [STATUS_W-1:0] status_t;

    localparam req_code_t REQ_INSERT  = 2'd0;
    localparam req_code_t REQ_UPSERT  = 2'd1;
    localparam req_code_t REQ_DEQUEUE = 2'd2;
    localparam req_code_t REQ_NONE    = 2'd3;

    localparam status_t ST_OK       = 2'd0;
    localparam status_t ST_EMPTY    = 2'd1;
    localparam status_t ST_DROPPED  = 2'd2;

    typedef enum logic [1:0] {
        OP_KEEP,
        OP_NEW,
        OP_FROM_PREV,
        OP_FROM_NEXT
    } cell_op_t;

    typedef enum logic {
        CTL_IDLE,
        CTL_UPDATE
    } ctl_state_t;

    typedef struct packed {
        logic gt;
        logic ge;
        logic mt;
    } cell_flags_t;

    typedef struct packed {
        logic    inc;
        logic    dec;
        status_t status;
    } plan_res_t;

endpackage

@@ rtl/spq_if.sv @@
interface spq_req_if;
    logic               valid;
    logic               ready;
    spq_pkg::req_code_t req_type;
    spq_pkg::item_t     item_id;
    spq_pkg::key_t      key;

    modport source (output valid, output req_type, output item_id, output key, input ready);
    modport sink   (input valid, input req_type, input item_id, input key, output ready);
endinterface

interface spq_res_if;
    logic             valid;
    logic             ready;
    spq_pkg::item_t   out_item;
    logic             out_valid;
    logic             now_empty;
    spq_pkg::status_t status;

    modport source (output valid, output out_item, output out_valid, output now_empty,
                    output status, input ready);
    modport sink   (input valid, input out_item, input out_valid, input now_empty,
                    input status, output ready);
endinterface

@@ rtl/spq_cell.sv @@
module spq_cell (
    input  logic                  clk,
    input  logic                  cmp_en,
    input  logic                  occ,
    input  spq_pkg::key_t         cmp_key,
    input  spq_pkg::item_t        cmp_item,
    input  spq_pkg::cell_op_t     op,
    input  spq_pkg::key_t         new_key,
    input  spq_pkg::item_t        new_item,
    input  spq_pkg::key_t         prev_key,
    input  spq_pkg::item_t        prev_item,
    input  spq_pkg::key_t         next_key,
    input  spq_pkg::item_t        next_item,
    output spq_pkg::key_t         key,
    output spq_pkg::item_t        item,
    output spq_pkg::cell_flags_t  flags
);

    spq_pkg::key_t        key_reg, key_next;
    spq_pkg::item_t       item_reg, item_next;
    spq_pkg::cell_flags_t flags_reg, flags_next;

    always_comb
    begin
        flags_next.gt = occ && (key_reg > cmp_key);
        flags_next.ge = occ && (key_reg >= cmp_key);
        flags_next.mt = occ && (item_reg == cmp_item);
    end

    always_comb
    begin
        key_next  = key_reg;
        item_next = item_reg;
        case (op)
            spq_pkg::OP_NEW:
            begin
                key_next  = new_key;
                item_next = new_item;
            end
            spq_pkg::OP_FROM_PREV:
            begin
                key_next  = prev_key;
                item_next = prev_item;
            end
            spq_pkg::OP_FROM_NEXT:
            begin
                key_next  = next_key;
                item_next = next_item;
            end
            default:
            begin
                key_next  = key_reg;
                item_next = item_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        key_reg  <= key_next;
        item_reg <= item_next;
        if (cmp_en)
        begin
            flags_reg <= flags_next;
        end
    end

    assign key   = key_reg;
    assign item  = item_reg;
    assign flags = flags_reg;

endmodule

@@ rtl/spq_plan.sv @@
module spq_plan #(
    parameter int N = 64
) (
    input  spq_pkg::req_code_t req_type,
    input  logic [N-1:0]       gt,
    input  logic [N-1:0]       ge,
    input  logic [N-1:0]       mt,
    input  logic [N-1:0]       occ,
    input  logic               full,
    input  logic               empty,
    output spq_pkg::cell_op_t  op [N],
    output spq_pkg::plan_res_t res
);

    logic [N-1:0] geu, gtu, geu_prev, gtu_prev;
    logic [N-1:0] le_t, lowm, highm, lowm_rev, low_last_rev, a_low, a_high, a_hot;
    logic [N-1:0] ge_a, fwd, fwd_end, bwd, bwd_start;
    logic         found, a_before_t;

    assign geu      = ge | ~occ;
    assign gtu      = gt | ~occ;
    assign geu_prev = geu << 1;
    assign gtu_prev = gtu << 1;

    // the last match at or before the first greater key, else the first match after it
    assign le_t  = ~gtu_prev;
    assign lowm  = mt & le_t;
    assign highm = mt & ~le_t;
    assign found = |mt;

    for (genvar g = 0; g < N; g++)
    begin : g_rev
        assign lowm_rev[g]  = lowm[N-1-g];
        assign a_low[N-1-g] = low_last_rev[g];
    end

    assign low_last_rev = lowm_rev & (~lowm_rev + N'(1));
    assign a_high       = highm & (~highm + N'(1));
    assign a_hot        = (|lowm) ? a_low : a_high;

    assign ge_a       = ~a_hot + N'(1);
    assign a_before_t = |(a_hot & ~gtu);
    assign fwd        = ge_a & ~gtu;
    assign fwd_end    = fwd & ~(fwd >> 1);
    assign bwd        = gtu & ~(ge_a << 1);
    assign bwd_start  = bwd & ~(bwd << 1);

    always_comb
    begin
        res.inc    = 1'b0;
        res.dec    = 1'b0;
        res.status = spq_pkg::ST_OK;
        unique case (req_type)
            spq_pkg::REQ_INSERT:
            begin
                if (full)
                begin
                    res.status = spq_pkg::ST_DROPPED;
                end
                else
                begin
                    res.inc = 1'b1;
                end
            end
            spq_pkg::REQ_UPSERT:
            begin
                if (!found && full)
                begin
                    res.status = spq_pkg::ST_DROPPED;
                end
                else if (!found)
                begin
                    res.inc = 1'b1;
                end
            end
            spq_pkg::REQ_DEQUEUE:
            begin
                if (empty)
                begin
                    res.status = spq_pkg::ST_EMPTY;
                end
                else
                begin
                    res.dec = 1'b1;
                end
            end
            default:
            begin
                res.status = spq_pkg::ST_OK;
            end
        endcase
    end

    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            op[i] = spq_pkg::OP_KEEP;
            unique case (req_type)
                spq_pkg::REQ_INSERT:
                begin
                    if (!full)
                    begin
                        if (geu_prev[i])
                        begin
                            op[i] = spq_pkg::OP_FROM_PREV;
                        end
                        else if (geu[i])
                        begin
                            op[i] = spq_pkg::OP_NEW;
                        end
                    end
                end
                spq_pkg::REQ_UPSERT:
                begin
                    if (found && a_before_t)
                    begin
                        if (fwd_end[i])
                        begin
                            op[i] = spq_pkg::OP_NEW;
                        end
                        else if (fwd[i])
                        begin
                            op[i] = spq_pkg::OP_FROM_NEXT;
                        end
                    end
                    else if (found)
                    begin
                        if (bwd_start[i])
                        begin
                            op[i] = spq_pkg::OP_NEW;
                        end
                        else if (bwd[i])
                        begin
                            op[i] = spq_pkg::OP_FROM_PREV;
                        end
                    end
                    else if (!full)
                    begin
                        if (gtu_prev[i])
                        begin
                            op[i] = spq_pkg::OP_FROM_PREV;
                        end
                        else if (gtu[i])
                        begin
                            op[i] = spq_pkg::OP_NEW;
                        end
                    end
                end
                spq_pkg::REQ_DEQUEUE:
                begin
                    if (!empty)
                    begin
                        op[i] = spq_pkg::OP_FROM_NEXT;
                    end
                end
                default:
                begin
                    op[i] = spq_pkg::OP_KEEP;
                end
            endcase
        end
    end

endmodule

@@ rtl/sorted_priority_queue_with_update.sv @@
// Sorted priority queue of (item, key) entries held in a row of CAPACITY cells, lowest key in
// cell 0. Each item has an accept cycle and an update cycle: in the accept cycle every cell
// compares its entry with the request key and item, in the update cycle the cells shift one
// place toward or away from the head and the result is loaded into the output register. The
// next item is accepted the cycle after that. The update cycle waits while an earlier result
// is still held on the output. There is no clearing pass after reset; the queue starts empty.
module sorted_priority_queue_with_update #(
    parameter int CAPACITY = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    spq_req_if.sink      req,
    spq_res_if.source    res
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    spq_pkg::ctl_state_t  state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    spq_pkg::req_code_t   req_type_reg;
    spq_pkg::item_t       item_reg;
    spq_pkg::key_t        key_reg;

    logic                 res_valid_reg, res_valid_next;
    spq_pkg::item_t       out_item_reg;
    logic                 out_valid_reg;
    logic                 now_empty_reg;
    spq_pkg::status_t     status_reg;

    logic                 accept, cmp_en, upd_en, out_hold;
    logic                 full, empty;
    logic [CAPACITY-1:0]  occ, gt_v, ge_v, mt_v;

    spq_pkg::key_t        cell_key  [CAPACITY];
    spq_pkg::item_t       cell_item [CAPACITY];
    spq_pkg::cell_flags_t cell_flags[CAPACITY];
    spq_pkg::cell_op_t    plan_op   [CAPACITY];
    spq_pkg::cell_op_t    cell_op   [CAPACITY];
    spq_pkg::plan_res_t   plan;

    assign full     = (count_reg == CNT_W'(CAPACITY));
    assign empty    = (count_reg == '0);
    assign out_hold = res_valid_reg && !res.ready;
    assign accept   = req.valid && req.ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            spq_pkg::CTL_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = spq_pkg::CTL_UPDATE;
                end
            end
            spq_pkg::CTL_UPDATE:
            begin
                if (!out_hold)
                begin
                    state_next = spq_pkg::CTL_IDLE;
                end
            end
            default:
            begin
                state_next = spq_pkg::CTL_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req.ready = 1'b0;
        cmp_en    = 1'b0;
        upd_en    = 1'b0;
        unique case (state_reg)
            spq_pkg::CTL_IDLE:
            begin
                req.ready = 1'b1;
                cmp_en    = req.valid;
            end
            spq_pkg::CTL_UPDATE:
            begin
                upd_en = !out_hold;
            end
            default:
            begin
                req.ready = 1'b0;
            end
        endcase
    end

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        spq_pkg::key_t  prev_key, next_key;
        spq_pkg::item_t prev_item, next_item;

        if (i == 0)
        begin : g_head
            assign prev_key  = key_reg;
            assign prev_item = item_reg;
        end
        else
        begin : g_mid
            assign prev_key  = cell_key[i-1];
            assign prev_item = cell_item[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            assign next_key  = cell_key[i];
            assign next_item = cell_item[i];
        end
        else
        begin : g_body
            assign next_key  = cell_key[i+1];
            assign next_item = cell_item[i+1];
        end

        assign occ[i]     = (count_reg > CNT_W'(i));
        assign gt_v[i]    = cell_flags[i].gt;
        assign ge_v[i]    = cell_flags[i].ge;
        assign mt_v[i]    = cell_flags[i].mt;
        assign cell_op[i] = upd_en ? plan_op[i] : spq_pkg::OP_KEEP;

        spq_cell u_cell (
            .clk       (clk),
            .cmp_en    (cmp_en),
            .occ       (occ[i]),
            .cmp_key   (req.key),
            .cmp_item  (req.item_id),
            .op        (cell_op[i]),
            .new_key   (key_reg),
            .new_item  (item_reg),
            .prev_key  (prev_key),
            .prev_item (prev_item),
            .next_key  (next_key),
            .next_item (next_item),
            .key       (cell_key[i]),
            .item      (cell_item[i]),
            .flags     (cell_flags[i])
        );
    end

    spq_plan #(
        .N (CAPACITY)
    ) u_plan (
        .req_type (req_type_reg),
        .gt       (gt_v),
        .ge       (ge_v),
        .mt       (mt_v),
        .occ      (occ),
        .full     (full),
        .empty    (empty),
        .op       (plan_op),
        .res      (plan)
    );

    always_comb
    begin
        count_next = count_reg;
        if (upd_en && plan.inc)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (upd_en && plan.dec)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (upd_en)
        begin
            res_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= spq_pkg::CTL_IDLE;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_type_reg <= req.req_type;
            item_reg     <= req.item_id;
            key_reg      <= req.key;
        end
        if (upd_en)
        begin
            out_item_reg  <= plan.dec ? cell_item[0] : '0;
            out_valid_reg <= plan.dec;
            now_empty_reg <= (count_next == '0);
            status_reg    <= plan.status;
        end
    end

    assign res.valid     = res_valid_reg;
    assign res.out_item  = out_item_reg;
    assign res.out_valid = out_valid_reg;
    assign res.now_empty = now_empty_reg;
    assign res.status    = status_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count beyond capacity");

    a_accept_update: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == spq_pkg::CTL_UPDATE && !req.ready)
        else $error("accepted item not followed by update");

    a_dequeue_count: assert property (@(posedge clk) disable iff (!rst_n)
        upd_en && plan.dec |=> count_reg == $past(count_reg) - CNT_W'(1) && res.out_valid)
        else $error("dequeue did not shrink the queue");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res.valid) |-> $past(state_reg) == spq_pkg::CTL_UPDATE)
        else $error("result without an update cycle");

endmodule

@@ dv/tb_sorted_priority_queue_with_update.sv @@
`timescale 1ns / 1ps

module tb_sorted_priority_queue_with_update;

    localparam int QUEUE_DEPTH = 64;

    typedef struct packed {
        spq_pkg::item_t   out_item;
        logic             out_valid;
        logic             now_empty;
        spq_pkg::status_t status;
    } queue_result_t;

    logic clk;
    logic rst_n;

    spq_req_if req_bus ();
    spq_res_if res_bus ();

    sorted_priority_queue_with_update #(
        .CAPACITY(QUEUE_DEPTH)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .res   (res_bus)
    );

    // shadow of the queue contents, lowest key at index 0
    spq_pkg::key_t  shadow_keys [QUEUE_DEPTH];
    spq_pkg::item_t shadow_items[QUEUE_DEPTH];
    int             shadow_count;

    queue_result_t pending_results[$];
    int            mismatch_count;
    bit            source_gaps_on;
    bit            sink_stalls_on;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    initial
    begin
        #2_000_000;
        $display("tb_sorted_priority_queue_with_update: errors");
        $finish;
    end

    function automatic void place_entry(int pos, spq_pkg::item_t id, spq_pkg::key_t k);
        if (shadow_count >= QUEUE_DEPTH || pos > shadow_count)
            return;
        for (int i = shadow_count; i > pos; i--)
        begin
            shadow_keys[i]  = shadow_keys[i-1];
            shadow_items[i] = shadow_items[i-1];
        end
        shadow_keys[pos]  = k;
        shadow_items[pos] = id;
        shadow_count++;
    endfunction

    function automatic void remove_entry(int pos);
        if (pos >= shadow_count)
            return;
        for (int i = pos; i + 1 < shadow_count; i++)
        begin
            shadow_keys[i]  = shadow_keys[i+1];
            shadow_items[i] = shadow_items[i+1];
        end
        shadow_count--;
    endfunction

    function automatic queue_result_t apply_request(spq_pkg::req_code_t rt,
                                                    spq_pkg::item_t id, spq_pkg::key_t k);
        queue_result_t r;
        int            pos;
        int            hit_pos;
        int            gt_pos;
        int            dest;
        bit            found;
        bit            greater;
        r = '0;
        case (rt)
            spq_pkg::REQ_INSERT:
            begin
                if (shadow_count >= QUEUE_DEPTH)
                    r.status = spq_pkg::ST_DROPPED;
                else
                begin
                    pos = 0;
                    while (pos < shadow_count && shadow_keys[pos] < k)
                        pos++;
                    place_entry(pos, id, k);
                end
            end
            spq_pkg::REQ_UPSERT:
            begin
                found   = 1'b0;
                greater = 1'b0;
                hit_pos = 0;
                gt_pos  = 0;
                for (int i = 0; i < shadow_count && !(found && greater); i++)
                begin
                    if (shadow_items[i] == id)
                    begin
                        found   = 1'b1;
                        hit_pos = i;
                    end
                    if (!greater && shadow_keys[i] > k)
                    begin
                        greater = 1'b1;
                        gt_pos  = i;
                    end
                end
                if (found)
                begin
                    if (greater && gt_pos == hit_pos)
                        shadow_keys[hit_pos] = k;
                    else
                    begin
                        remove_entry(hit_pos);
                        if (!greater)
                            dest = shadow_count;
                        else if (gt_pos > hit_pos)
                            dest = gt_pos - 1;
                        else
                            dest = gt_pos;
                        place_entry(dest, id, k);
                    end
                end
                else if (shadow_count >= QUEUE_DEPTH)
                    r.status = spq_pkg::ST_DROPPED;
                else
                    place_entry(greater ? gt_pos : shadow_count, id, k);
            end
            spq_pkg::REQ_DEQUEUE:
            begin
                if (shadow_count == 0)
                    r.status = spq_pkg::ST_EMPTY;
                else
                begin
                    r.out_item  = shadow_items[0];
                    r.out_valid = 1'b1;
                    remove_entry(0);
                end
            end
            default:
            begin
            end
        endcase
        r.now_empty = (shadow_count == 0);
        return r;
    endfunction

    // callers resume right after the accepting clock edge
    task automatic send_req(spq_pkg::req_code_t rt, spq_pkg::item_t id, spq_pkg::key_t k);
        @(negedge clk);
        while (source_gaps_on && $urandom_range(99) < 33)
        begin
            req_bus.valid <= 1'b0;
            @(negedge clk);
        end
        req_bus.valid    <= 1'b1;
        req_bus.req_type <= rt;
        req_bus.item_id  <= id;
        req_bus.key      <= k;
        do
            @(posedge clk);
        while (!req_bus.ready);
        pending_results.push_back(apply_request(rt, id, k));
    endtask

    task automatic wait_drain();
        @(negedge clk);
        req_bus.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    function automatic spq_pkg::key_t pick_key();
        int sel;
        sel = $urandom_range(99);
        if (sel < 40)
            return spq_pkg::key_t'($urandom_range(15));
        if (sel < 65 && shadow_count > 0)
            return shadow_keys[$urandom_range(shadow_count - 1)];
        if (sel < 70)
            return 32'hFFFF_FFFF;
        return spq_pkg::key_t'($urandom());
    endfunction

    function automatic spq_pkg::item_t pick_item();
        int sel;
        sel = $urandom_range(99);
        if (sel < 50)
            return spq_pkg::item_t'($urandom_range(31));
        if (sel < 75 && shadow_count > 0)
            return shadow_items[$urandom_range(shadow_count - 1)];
        return spq_pkg::item_t'($urandom());
    endfunction

    function automatic spq_pkg::req_code_t pick_req(bit grow);
        int sel;
        sel = $urandom_range(99);
        if (grow)
        begin
            if (sel < 45) return spq_pkg::REQ_INSERT;
            if (sel < 80) return spq_pkg::REQ_UPSERT;
            if (sel < 96) return spq_pkg::REQ_DEQUEUE;
            return spq_pkg::REQ_NONE;
        end
        if (sel < 15) return spq_pkg::REQ_INSERT;
        if (sel < 30) return spq_pkg::REQ_UPSERT;
        if (sel < 95) return spq_pkg::REQ_DEQUEUE;
        return spq_pkg::REQ_NONE;
    endfunction

    task automatic test_empty_queue();
        send_req(spq_pkg::REQ_DEQUEUE, 16'h0000, 32'h0000_0000);
        send_req(spq_pkg::REQ_NONE, 16'hFFFF, 32'hFFFF_FFFF);
    endtask

    task automatic test_order_and_ties();
        send_req(spq_pkg::REQ_INSERT, 16'hFFFF, 32'hFFFF_FFFF);
        send_req(spq_pkg::REQ_INSERT, 16'h0000, 32'h0000_0000);
        send_req(spq_pkg::REQ_INSERT, 16'hA5A5, 32'h0001_8000);
        // equal key goes ahead of the stored one
        send_req(spq_pkg::REQ_INSERT, 16'h5A5A, 32'h0001_8000);
        // new item by upsert goes behind equal keys
        send_req(spq_pkg::REQ_UPSERT, 16'h3C3C, 32'h0001_8000);
        send_req(spq_pkg::REQ_NONE, 16'h1234, 32'h0000_0005);
        send_req(spq_pkg::REQ_DEQUEUE, 16'h0000, 32'h0000_0000);
        send_req(spq_pkg::REQ_DEQUEUE, 16'h0000, 32'h0000_0000);
    endtask

    task automatic test_update_cases();
        // stays in place with a lower key
        send_req(spq_pkg::REQ_UPSERT, 16'hA5A5, 32'h0001_0000);
        // nothing greater, moves to the tail
        send_req(spq_pkg::REQ_UPSERT, 16'hA5A5, 32'hFFFF_FFFF);
        send_req(spq_pkg::REQ_UPSERT, 16'hFFFF, 32'h0000_0000);
        // duplicate item ids
        send_req(spq_pkg::REQ_INSERT, 16'h3C3C, 32'h0002_0000);
        send_req(spq_pkg::REQ_UPSERT, 16'h3C3C, 32'h0003_0000);
        repeat (6)
            send_req(spq_pkg::REQ_DEQUEUE, 16'h0000, 32'h0000_0000);
        // single entry
        send_req(spq_pkg::REQ_INSERT, 16'h0007, 32'h0000_0064);
        send_req(spq_pkg::REQ_UPSERT, 16'h0007, 32'h0000_0032);
        send_req(spq_pkg::REQ_UPSERT, 16'h0007, 32'h0000_00C8);
        send_req(spq_pkg::REQ_DEQUEUE, 16'h0000, 32'h0000_0000);
    endtask

    task automatic test_full_queue();
        while (shadow_count < QUEUE_DEPTH)
            send_req(spq_pkg::REQ_INSERT, spq_pkg::item_t'($urandom_range(16'h7FFF)),
                     pick_key());
        send_req(spq_pkg::REQ_INSERT, spq_pkg::item_t'($urandom()), pick_key());
        send_req(spq_pkg::REQ_UPSERT, 16'h8000 | spq_pkg::item_t'($urandom()), pick_key());
        // present item is moved, never dropped
        send_req(spq_pkg::REQ_UPSERT, shadow_items[$urandom_range(QUEUE_DEPTH - 1)],
                 pick_key());
        send_req(spq_pkg::REQ_UPSERT, shadow_items[0], 32'hFFFF_FFFF);
        send_req(spq_pkg::REQ_UPSERT, shadow_items[QUEUE_DEPTH - 1], 32'h0000_0000);
        while (shadow_count > 0)
            send_req(spq_pkg::REQ_DEQUEUE, pick_item(), pick_key());
    endtask

    task automatic test_random_traffic(int n_items);
        int                 done;
        int                 run_len;
        bit                 grow;
        spq_pkg::req_code_t rt;
        done = 0;
        grow = 1'b1;
        while (done < n_items)
        begin
            run_len = $urandom_range(10, 90);
            for (int i = 0; i < run_len && done < n_items; i++)
            begin
                rt = pick_req(grow);
                send_req(rt, pick_item(), pick_key());
                if (rt != spq_pkg::REQ_NONE)
                    done++;
            end
            grow = ~grow;
        end
    endtask

    task automatic test_back_to_back(int n_items);
        source_gaps_on = 1'b0;
        sink_stalls_on = 1'b0;
        test_random_traffic(n_items);
        source_gaps_on = 1'b1;
        sink_stalls_on = 1'b1;
    endtask

    task automatic check_result();
        queue_result_t want;
        if (pending_results.size() == 0)
        begin
            $error("unexpected result: item %h valid %b empty %b status %0d",
                   res_bus.out_item, res_bus.out_valid, res_bus.now_empty, res_bus.status);
            mismatch_count++;
            return;
        end
        want = pending_results.pop_front();
        if (res_bus.out_item !== want.out_item)
        begin
            $error("out_item: expected %h, got %h", want.out_item, res_bus.out_item);
            mismatch_count++;
        end
        if (res_bus.out_valid !== want.out_valid)
        begin
            $error("out_valid: expected %b, got %b", want.out_valid, res_bus.out_valid);
            mismatch_count++;
        end
        if (res_bus.now_empty !== want.now_empty)
        begin
            $error("now_empty: expected %b, got %b", want.now_empty, res_bus.now_empty);
            mismatch_count++;
        end
        if (res_bus.status !== want.status)
        begin
            $error("status: expected %0d, got %0d", want.status, res_bus.status);
            mismatch_count++;
        end
    endtask

    initial
    begin
        res_bus.ready <= 1'b0;
        forever
        begin
            @(negedge clk);
            res_bus.ready <= !(sink_stalls_on && $urandom_range(99) < 33);
            @(posedge clk);
            if (res_bus.valid && res_bus.ready)
                check_result();
        end
    end

    initial
    begin
        mismatch_count   = 0;
        shadow_count     = 0;
        source_gaps_on   = 1'b1;
        sink_stalls_on   = 1'b1;
        rst_n            = 1'b0;
        req_bus.valid    <= 1'b0;
        req_bus.req_type <= spq_pkg::REQ_NONE;
        req_bus.item_id  <= '0;
        req_bus.key      <= '0;
        repeat (12)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_empty_queue();
        test_order_and_ties();
        test_update_cases();
        wait_drain();
        test_full_queue();
        test_random_traffic(310);
        wait_drain();
        test_back_to_back(150);
        wait_drain();

        repeat (20)
            @(posedge clk);
        if (mismatch_count == 0)
            $display("tb_sorted_priority_queue_with_update: clean");
        else
            $display("tb_sorted_priority_queue_with_update: errors");
        $finish;
    end

endmodule
